>>> src/cmms_pkg.sv
package cmms_pkg;

   // Default sizing
   localparam int MAX_CHARS_DEF    = 64;
   localparam int MAX_WORD_LEN_DEF = 8;
   localparam int LOGCF_BITS_DEF   = 10;

   // Rule that decided the winning candidate
   localparam logic [1:0] RULE_MAX_LEN = 2'd0;
   localparam logic [1:0] RULE_AVG_LEN = 2'd1;
   localparam logic [1:0] RULE_VAR     = 2'd2;
   localparam logic [1:0] RULE_LOGF    = 2'd3;

   typedef struct packed {
      logic [6:0] char_word_mask;
      logic [9:0] char_logcf;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [5:0] word_start;
      logic [3:0] word_length;
      logic [1:0] rule_taken;
      logic       chunk_truncated;
      logic       last_word;
   } rsp_type;

endpackage

>>> src/complex_max_match_segmenter_top.sv
// Loading: one character transaction per cycle, no result until last_char.
// Segmenting: each word walks all MAX_WORD_LEN*(MAX_WORD_LEN+1)^2 candidates;
// one that does not fit is rejected without a read, and one that fits is
// checked word by word with up to 3 reads through the shared RAM read address.
// One result at a time; a new chunk is taken after the last word is taken.
// Reset clears the sequencer, count and overflow flag; the stores are not cleared.
module complex_max_match_segmenter_top #(
   parameter int MAX_CHARS    = cmms_pkg::MAX_CHARS_DEF,
   parameter int MAX_WORD_LEN = cmms_pkg::MAX_WORD_LEN_DEF,
   parameter int LOGCF_BITS   = cmms_pkg::LOGCF_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cmms_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cmms_pkg::rsp_type rsp_payload
);

   localparam int ADDR_W = $clog2(MAX_CHARS);
   localparam int CNT_W  = $clog2(MAX_CHARS+1);
   localparam int WLEN_W = $clog2(MAX_WORD_LEN+1);
   localparam int TOT_W  = $clog2(3*MAX_WORD_LEN+1);
   localparam int SQ_W   = $clog2(3*MAX_WORD_LEN*MAX_WORD_LEN+1);
   localparam int LS_W   = LOGCF_BITS + 2;
   localparam int CMP_W  = CNT_W + TOT_W;
   localparam logic [WLEN_W-1:0] MAXW = WLEN_W'(MAX_WORD_LEN);

   typedef enum logic [2:0] {
      S_LOAD, S_START, S_CAND, S_READ, S_CHECK, S_WORD, S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [WLEN_W-1:0]  a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [1:0]         k_ff, k_in;
   logic [1:0]         nw_ff, nw_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [LS_W-1:0]    ls_ff, ls_in;
   cmms_pkg::rsp_type  rsp_ff, rsp_in;

   logic                  accept, wr_en;
   logic [LOGCF_BITS+9:0] logcf_ext;
   logic [6:0]            mask_rd;
   logic [LOGCF_BITS-1:0] logcf_rd;
   logic [WLEN_W-1:0]     cur_w;
   logic [CMP_W-1:0]      word_pos;
   logic [ADDR_W-1:0]     rd_addr;
   logic [2:0]            bit_idx;
   logic                  fits, word_ok;
   logic [1:0]            nw_next;
   logic [SQ_W-1:0]       sq_next;
   logic [LS_W-1:0]       ls_next;
   logic [WLEN_W-1:0]     adv_a, adv_b, adv_c;
   logic                  adv_done;
   logic                  cand_valid;
   logic [WLEN_W-1:0]     best_first;
   logic [1:0]            best_rule;
   logic [CNT_W-1:0]      next_pos;

   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept && (count_ff < CNT_W'(MAX_CHARS));
   assign logcf_ext = {LOGCF_BITS'(0), req_payload.char_logcf};

   cmms_ram #(.WIDTH(7), .DEPTH(MAX_CHARS)) u_mask_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_payload.char_word_mask),
      .rd_addr (rd_addr),
      .rd_data (mask_rd)
   );

   cmms_ram #(.WIDTH(LOGCF_BITS), .DEPTH(MAX_CHARS)) u_logcf_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (logcf_ext[LOGCF_BITS-1:0]),
      .rd_addr (rd_addr),
      .rd_data (logcf_rd)
   );

   cmms_score #(.MAX_WORD_LEN(MAX_WORD_LEN), .LOGCF_BITS(LOGCF_BITS)) u_score (
      .clock       (clock),
      .clear       (state_ff == S_START),
      .cand_valid  (cand_valid),
      .cand_total  (TOT_W'(a_ff) + TOT_W'(b_ff) + TOT_W'(c_ff)),
      .cand_nwords (nw_next),
      .cand_sumsq  (sq_next),
      .cand_logsum (ls_next),
      .cand_first  (a_ff),
      .best_first  (best_first),
      .best_rule   (best_rule)
   );

   // Word k of the current candidate: length and start position
   always_comb begin
      case (k_ff)
         2'd0:    cur_w = a_ff;
         2'd1:    cur_w = b_ff;
         default: cur_w = c_ff;
      endcase
      word_pos = CMP_W'(pos_ff) + ((k_ff != 2'd0) ? CMP_W'(a_ff) : '0)
               + ((k_ff == 2'd2) ? CMP_W'(b_ff) : '0);
   end
   assign rd_addr = word_pos[ADDR_W-1:0];
   assign bit_idx = 3'(cur_w - WLEN_W'(2));

   // Fit in the rest of the chunk; empty second word forces empty third
   assign fits = (CMP_W'(a_ff) + CMP_W'(b_ff) + CMP_W'(c_ff) <= CMP_W'(count_ff - pos_ff))
              && !(b_ff == '0 && c_ff != '0);
   assign word_ok = (cur_w < WLEN_W'(2)) || mask_rd[bit_idx];

   // Candidate metrics accumulated word by word
   assign nw_next = nw_ff + {1'b0, (cur_w != '0)};
   assign sq_next = sq_ff + SQ_W'(SQ_W'(cur_w) * SQ_W'(cur_w));
   assign ls_next = ls_ff + ((cur_w == WLEN_W'(1)) ? LS_W'(logcf_rd) : '0);
   assign cand_valid = (state_ff == S_CHECK) && word_ok && (k_ff == 2'd2);

   // Enumeration step: first length fastest, third slowest
   always_comb begin
      adv_a    = a_ff;
      adv_b    = b_ff;
      adv_c    = c_ff;
      adv_done = 1'b0;
      if (a_ff > WLEN_W'(1)) begin
         adv_a = a_ff - WLEN_W'(1);
      end else if (b_ff != '0) begin
         adv_b = b_ff - WLEN_W'(1);
         adv_a = MAXW;
      end else if (c_ff != '0) begin
         adv_c = c_ff - WLEN_W'(1);
         adv_b = MAXW;
         adv_a = MAXW;
      end else begin
         adv_done = 1'b1;
      end
   end

   assign next_pos = pos_ff + CNT_W'(best_first);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      pos_in   = pos_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      nw_in    = nw_ff;
      sq_in    = sq_ff;
      ls_in    = ls_ff;
      rsp_in   = rsp_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_payload.last_char) begin
                  pos_in   = '0;
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            a_in     = MAXW;
            b_in     = MAXW;
            c_in     = MAXW;
            state_in = S_CAND;
         end
         S_CAND: begin
            k_in  = 2'd0;
            nw_in = '0;
            sq_in = '0;
            ls_in = '0;
            if (fits) begin
               state_in = S_READ;
            end else begin
               a_in     = adv_a;
               b_in     = adv_b;
               c_in     = adv_c;
               state_in = adv_done ? S_WORD : S_CAND;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (word_ok && k_ff != 2'd2) begin
               nw_in    = nw_next;
               sq_in    = sq_next;
               ls_in    = ls_next;
               k_in     = k_ff + 2'd1;
               state_in = S_READ;
            end else begin
               a_in     = adv_a;
               b_in     = adv_b;
               c_in     = adv_c;
               state_in = adv_done ? S_WORD : S_CAND;
            end
         end
         S_WORD: begin
            rsp_in.word_start      = pos_ff[5:0];
            rsp_in.word_length     = 4'(best_first);
            rsp_in.rule_taken      = best_rule;
            rsp_in.chunk_truncated = ovf_ff;
            rsp_in.last_word       = next_pos >= count_ff;
            pos_in                 = next_pos;
            state_in               = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               if (rsp_ff.last_word) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_START;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
      pos_ff <= pos_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      k_ff   <= k_in;
      nw_ff  <= nw_in;
      sq_ff  <= sq_in;
      ls_ff  <= ls_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall   = (state_ff != S_LOAD);
   assign rsp_valid   = (state_ff == S_EMIT);
   assign rsp_payload = rsp_ff;

endmodule

>>> src/cmms_ram.sv
module cmms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/cmms_score.sv
module cmms_score #(
   parameter int MAX_WORD_LEN = cmms_pkg::MAX_WORD_LEN_DEF,
   parameter int LOGCF_BITS   = cmms_pkg::LOGCF_BITS_DEF
) (
   input  logic                                               clock,
   input  logic                                               clear,
   input  logic                                               cand_valid,
   input  logic [$clog2(3*MAX_WORD_LEN+1)-1:0]                cand_total,
   input  logic [1:0]                                         cand_nwords,
   input  logic [$clog2(3*MAX_WORD_LEN*MAX_WORD_LEN+1)-1:0]   cand_sumsq,
   input  logic [LOGCF_BITS+1:0]                              cand_logsum,
   input  logic [$clog2(MAX_WORD_LEN+1)-1:0]                  cand_first,
   output logic [$clog2(MAX_WORD_LEN+1)-1:0]                  best_first,
   output logic [1:0]                                         best_rule
);

   localparam int TOT_W  = $clog2(3*MAX_WORD_LEN+1);
   localparam int SQ_W   = $clog2(3*MAX_WORD_LEN*MAX_WORD_LEN+1);
   localparam int LS_W   = LOGCF_BITS + 2;
   localparam int WLEN_W = $clog2(MAX_WORD_LEN+1);

   logic              have_ff, have_in;
   logic [TOT_W-1:0]  tot_ff, tot_in;
   logic [1:0]        nw_ff, nw_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [LS_W-1:0]   ls_ff, ls_in;
   logic [WLEN_W-1:0] first_ff, first_in;
   // tie counts saturate at two: only "exactly one" matters
   logic [1:0]        c0_ff, c0_in, c1_ff, c1_in, c2_ff, c2_in;
   logic              take;

   function automatic logic [1:0] sat_inc(input logic [1:0] v);
      return (v == 2'd2) ? v : v + 2'd1;
   endfunction

   // Running best and tie counts, one candidate per call
   always_comb begin
      have_in = have_ff;
      c0_in   = c0_ff;
      c1_in   = c1_ff;
      c2_in   = c2_ff;
      take    = 1'b0;
      if (clear) begin
         have_in = 1'b0;
      end else if (cand_valid) begin
         if (!have_ff || cand_total > tot_ff) begin
            take  = 1'b1;
            c0_in = 2'd1;
            c1_in = 2'd1;
            c2_in = 2'd1;
         end else if (cand_total == tot_ff) begin
            c0_in = sat_inc(c0_ff);
            if (cand_nwords < nw_ff) begin
               take  = 1'b1;
               c1_in = 2'd1;
               c2_in = 2'd1;
            end else if (cand_nwords == nw_ff) begin
               c1_in = sat_inc(c1_ff);
               if (cand_sumsq < sq_ff) begin
                  take  = 1'b1;
                  c2_in = 2'd1;
               end else if (cand_sumsq == sq_ff) begin
                  c2_in = sat_inc(c2_ff);
                  take  = cand_logsum > ls_ff;
               end
            end
         end
         have_in = 1'b1;
      end
      tot_in   = take ? cand_total  : tot_ff;
      nw_in    = take ? cand_nwords : nw_ff;
      sq_in    = take ? cand_sumsq  : sq_ff;
      ls_in    = take ? cand_logsum : ls_ff;
      first_in = take ? cand_first  : first_ff;
   end

   always_ff @(posedge clock) begin
      have_ff  <= have_in;
      tot_ff   <= tot_in;
      nw_ff    <= nw_in;
      sq_ff    <= sq_in;
      ls_ff    <= ls_in;
      first_ff <= first_in;
      c0_ff    <= c0_in;
      c1_ff    <= c1_in;
      c2_ff    <= c2_in;
   end

   assign best_first = first_ff;
   assign best_rule  = (c0_ff == 2'd1) ? cmms_pkg::RULE_MAX_LEN :
                       (c1_ff == 2'd1) ? cmms_pkg::RULE_AVG_LEN :
                       (c2_ff == 2'd1) ? cmms_pkg::RULE_VAR     : cmms_pkg::RULE_LOGF;

endmodule
